>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Operation codes, character codes, field widths and the control states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // field widths of the channels and the configuration port
  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUT    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SETCUR = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  // reset values of the color registers
  localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'hF;
  localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SCROLL,
    ST_FILL,
    ST_RDWAIT,
    ST_RESP
  } tcw_state_t;

endpackage

>>> hdl/tcw_in_if.sv
// ----------------------------------------------------------------------------
// tcw_in_if: request channel of the text console writer
// Valid/ready handshake carrying one console operation.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  position;

  modport source (output valid, output func, output char_code, output position,
                  input ready);
  modport sink (input valid, input func, input char_code, input position,
                output ready);
endinterface

>>> hdl/tcw_out_if.sv
// ----------------------------------------------------------------------------
// tcw_out_if: result channel of the text console writer
// Valid/ready handshake carrying the cursor and the read cell word.
// ----------------------------------------------------------------------------
interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, output cursor_pos, output cell_data, input ready);
  modport sink (input valid, input cursor_pos, input cell_data, output ready);
endinterface

>>> hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// ROWS x COLS cell store in one synchronous RAM, cursor, put/clear/set/read.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_ch     sink       valid/ready    func, char_code, position
//  out_ch    source     valid/ready    cursor_pos, cell_data
//  cfg_*     sink       cfg_wr_en      cfg_index, cfg_wdata (fg, bg nibbles)
//
//  put character, set cursor out of range, read out of range: done in ST_EXEC
//  read cell: registered RAM read, out in ST_RDWAIT; set cursor: column
//  from reciprocal multiply in ST_EXEC, multiply-back, subtract in ST_DIV
//  clear screen: ST_FILL blanks all cells; scrolling put: ST_SCROLL, ST_FILL
//  after reset a clearing pass zeroes the RAM, no requests
//  one request at a time; a finished result waits in the output register
//  while the next request is accepted
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tcw_in_if.sink                             in_ch,
  tcw_out_if.source                          out_ch,
  input  logic                               cfg_wr_en,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLS);
  // floor(pos / COLS) = (pos * RECIP) >> QSH for every 11-bit pos
  localparam int QSH   = POS_W + CLW;
  localparam int RECIP = ((1 << QSH) + COLS - 1) / COLS;
  localparam int PW    = 2 * POS_W + 1;

  tcw_state_t state_r, state_nxt;

  logic [CW-1:0]         cursor_r, cursor_nxt;
  logic [CLW-1:0]        col_r, col_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [POS_W-1:0]      quo_r, quo_nxt;
  logic                  fill_zero_r, fill_zero_nxt;
  logic                  cpy_pend_r, cpy_pend_nxt;
  logic [CELL_W-1:0]     data_r, data_nxt;

  logic [FUNC_W-1:0]     op_func_r;
  logic [CHAR_W-1:0]     op_char_r;
  logic [POS_W-1:0]      op_pos_r;

  logic [CFG_DATA_W-1:0] fg_r, bg_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]      out_cursor_r;
  logic [CELL_W-1:0]     out_data_r;

  logic                  mem_we, mem_re;
  logic [CW-1:0]         mem_waddr, mem_raddr;
  logic [CELL_W-1:0]     mem_wdata, mem_rdata_r;
  logic [CELL_W-1:0]     cells_mem [CELLS];

  logic                  in_acc, slot_free, out_load;
  logic                  fin;
  logic [CELL_W-1:0]     fin_data;
  logic [CELL_W-1:0]     blank_word;
  logic [CW-1:0]         cur_new;
  logic                  pos_ok;
  logic [PW-1:0]         quo_prod;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign blank_word = {bg_r, fg_r, CH_BLANK};
  assign pos_ok     = (32'(op_pos_r) < 32'(CELLS));
  assign quo_prod   = PW'(op_pos_r) * PW'(RECIP);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_pos = out_cursor_r;
  assign out_ch.cell_data  = out_data_r;

  // cell store
  always_ff @(posedge clk) begin
    if (mem_we) cells_mem[mem_waddr[AW-1:0]] <= mem_wdata;
    if (mem_re) mem_rdata_r <= cells_mem[mem_raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FG: fg_r <= cfg_wdata;
        CFG_BG: bg_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cursor_r    <= '0;
      col_r       <= '0;
      idx_r       <= '0;
      fill_zero_r <= 1'b1;
      cpy_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      idx_r       <= idx_nxt;
      fill_zero_r <= fill_zero_nxt;
      cpy_pend_r  <= cpy_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    data_r <= data_nxt;
    if (in_acc) begin
      op_func_r <= in_ch.func;
      op_char_r <= in_ch.char_code;
      op_pos_r  <= in_ch.position;
    end
    if (out_load) begin
      out_cursor_r <= POS_W'(cursor_nxt);
      out_data_r   <= data_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    quo_nxt       = quo_r;
    fill_zero_nxt = fill_zero_r;
    cpy_pend_nxt  = 1'b0;
    data_nxt      = data_r;
    mem_we        = 1'b0;
    mem_waddr     = cursor_r;
    mem_wdata     = blank_word;
    mem_re        = 1'b0;
    mem_raddr     = idx_r + CW'(COLS);
    fin           = 1'b0;
    fin_data      = '0;
    cur_new       = cursor_r;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        unique case (op_func_r)
          FN_PUT: begin
            priority if (op_char_r == CH_NEWLINE) begin
              cur_new = cursor_r + CW'(COLS) - CW'(col_r);
              col_nxt = '0;
            end else if (op_char_r == CH_BACKSPACE) begin
              // at cell zero the cursor stays and cell zero is blanked
              if (cursor_r != '0) begin
                cur_new = cursor_r - 1'b1;
                col_nxt = (col_r == '0) ? CLW'(COLS - 1) : col_r - 1'b1;
              end
              mem_we    = 1'b1;
              mem_waddr = cur_new;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {bg_r, fg_r, op_char_r};
              cur_new   = cursor_r + 1'b1;
              col_nxt   = (col_r == CLW'(COLS - 1)) ? '0 : col_r + 1'b1;
            end
            if (cur_new == CW'(CELLS)) begin
              cursor_nxt = CW'(CELLS - COLS);
              col_nxt    = '0;
              idx_nxt    = '0;
              state_nxt  = ST_SCROLL;
            end else begin
              cursor_nxt = cur_new;
              fin        = 1'b1;
            end
          end
          FN_CLEAR: begin
            cursor_nxt = '0;
            col_nxt    = '0;
            idx_nxt    = '0;
            state_nxt  = ST_FILL;
          end
          FN_SETCUR: begin
            if (pos_ok) begin
              cursor_nxt = CW'(op_pos_r);
              quo_nxt    = POS_W'(quo_prod >> QSH);
              state_nxt  = ST_DIV;
            end else begin
              fin = 1'b1;
            end
          end
          FN_READ: begin
            if (pos_ok) begin
              mem_re    = 1'b1;
              mem_raddr = CW'(op_pos_r);
              state_nxt = ST_RDWAIT;
            end else begin
              fin = 1'b1;
            end
          end
        endcase
      end

      // column of the new cursor: position minus row start
      ST_DIV: begin
        col_nxt = CLW'(op_pos_r - POS_W'(quo_r * POS_W'(COLS)));
        fin     = 1'b1;
      end

      // copy row r+1 into row r; the write comes in the cycle after its read
      ST_SCROLL: begin
        if (cpy_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - 1'b1;
          mem_wdata = mem_rdata_r;
        end
        if (idx_r < CW'(CELLS - COLS)) begin
          mem_re       = 1'b1;
          cpy_pend_nxt = 1'b1;
          idx_nxt      = idx_r + 1'b1;
        end else begin
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = fill_zero_r ? '0 : blank_word;
        if (idx_r == CW'(CELLS - 1)) begin
          if (fill_zero_r) begin
            fill_zero_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            fin = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_RDWAIT: begin
        fin      = 1'b1;
        fin_data = mem_rdata_r;
      end

      ST_RESP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (fin) begin
      data_nxt = fin_data;
      if (slot_free) begin
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_RESP;
      end
    end

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  // cursor always points inside the store between requests
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cursor_r < CW'(CELLS))
    else $error("cursor outside the cell store");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> col_r <= CLW'(COLS - 1))
    else $error("column outside the row");

  // no request is taken while the reset clearing pass runs
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fill_zero_r |-> !in_ch.ready)
    else $error("request taken during clearing pass");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_EXEC)
    else $error("accepted request not executed");

  // a waiting result is never overwritten
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !out_load)
    else $error("pending result overwritten");

endmodule

>>> tb/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Drives console requests through the valid/ready channels with random gaps
// and stalls. A behavioral copy of the cell store and cursor predicts each
// response not typed in by the directed corner-case table; then random text
// bursts, reads, cursor moves and clears run under several color settings.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = ROWS * COLS;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 3;
  localparam int MAX_WAIT       = 12;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 8;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int END_CYCLES     = 20;
  localparam int TIMEOUT_CYCLES = 3000000;
  localparam int DIR_N          = 26;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CELL_W-1:0] cell_word;
  } console_resp_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic              typed;
    logic [POS_W-1:0]  cursor;
    logic [CELL_W-1:0] cell_word;
  } dir_row_t;

  // expectations are typed in for the rows that follow from reset and corners
  dir_row_t directed_rows [0:DIR_N-1] = '{
    '{FN_READ,   8'h00,        11'd0,    1'b1, 11'd0,    16'h0000},
    '{FN_READ,   8'h00,        11'd1999, 1'b1, 11'd0,    16'h0000},
    '{FN_READ,   8'hFF,        11'd2000, 1'b1, 11'd0,    16'h0000},
    '{FN_READ,   8'h00,        11'd2047, 1'b1, 11'd0,    16'h0000},
    '{FN_PUT,    8'h41,        11'd0,    1'b1, 11'd1,    16'h0000},
    '{FN_READ,   8'h00,        11'd0,    1'b1, 11'd1,    16'h0F41},
    '{FN_PUT,    8'h00,        11'd0,    1'b1, 11'd2,    16'h0000},
    '{FN_PUT,    8'hFF,        11'd2047, 1'b1, 11'd3,    16'h0000},
    '{FN_READ,   8'h00,        11'd2,    1'b1, 11'd3,    16'h0FFF},
    '{FN_PUT,    CH_BACKSPACE, 11'd0,    1'b1, 11'd2,    16'h0000},
    '{FN_READ,   8'h00,        11'd2,    1'b1, 11'd2,    16'h0F20},
    '{FN_SETCUR, 8'h00,        11'd0,    1'b1, 11'd0,    16'h0000},
    '{FN_PUT,    CH_BACKSPACE, 11'd0,    1'b1, 11'd0,    16'h0000},
    '{FN_READ,   8'h00,        11'd0,    1'b1, 11'd0,    16'h0F20},
    '{FN_SETCUR, 8'h00,        11'd2047, 1'b1, 11'd0,    16'h0000},
    '{FN_SETCUR, 8'h00,        11'd2000, 1'b1, 11'd0,    16'h0000},
    '{FN_PUT,    CH_NEWLINE,   11'd0,    1'b1, 11'd80,   16'h0000},
    '{FN_READ,   8'h00,        11'd1,    1'b1, 11'd80,   16'h0F00},
    '{FN_SETCUR, 8'h00,        11'd1999, 1'b1, 11'd1999, 16'h0000},
    '{FN_PUT,    8'h5A,        11'd0,    1'b1, 11'd1920, 16'h0000},
    '{FN_READ,   8'h00,        11'd1919, 1'b1, 11'd1920, 16'h0F5A},
    '{FN_READ,   8'h00,        11'd1999, 1'b1, 11'd1920, 16'h0F20},
    '{FN_PUT,    CH_NEWLINE,   11'd0,    1'b1, 11'd1920, 16'h0000},
    '{FN_READ,   8'h00,        11'd1839, 1'b1, 11'd1920, 16'h0F5A},
    '{FN_CLEAR,  8'h00,        11'd0,    1'b1, 11'd0,    16'h0000},
    '{FN_PUT,    8'h7F,        11'd0,    1'b0, 11'd0,    16'h0000}
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // behavioral copy of the console
  logic [CELL_W-1:0]     screen_model [0:CELLS-1];
  int                    cursor_model;
  logic [CFG_DATA_W-1:0] fg_model;
  logic [CFG_DATA_W-1:0] bg_model;

  console_resp_t pending_results [$];
  int  errors;
  int  requests_sent;
  int  gap_max;
  int  stall_max;
  bit  hold_req;

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  function automatic console_resp_t console_apply(input logic [FUNC_W-1:0] f,
                                                  input logic [CHAR_W-1:0] c,
                                                  input logic [POS_W-1:0] p);
    console_resp_t r;
    logic [CELL_W-1:0] blank;
    blank = {bg_model, fg_model, CH_BLANK};
    r.cell_word = '0;
    if (cursor_model >= CELLS) cursor_model = 0;
    case (f)
      FN_PUT: begin
        if (c == CH_NEWLINE) begin
          cursor_model += COLS - (cursor_model % COLS);
        end else if (c == CH_BACKSPACE) begin
          if (cursor_model > 0) cursor_model--;
          screen_model[cursor_model] = blank;
        end else begin
          screen_model[cursor_model] = {bg_model, fg_model, c};
          cursor_model++;
        end
        // running off the end moves every row up one
        if (cursor_model >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = blank;
          cursor_model -= COLS;
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = blank;
        cursor_model = 0;
      end
      FN_SETCUR: begin
        if (int'(p) < CELLS) cursor_model = int'(p);
      end
      default: begin
        if (int'(p) < CELLS) r.cell_word = screen_model[p];
      end
    endcase
    r.cursor = cursor_model[POS_W-1:0];
    return r;
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                              input logic [POS_W-1:0] p, input bit typed,
                              input console_resp_t typed_resp);
    int gap;
    console_resp_t r;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func      = f;
    in_ch.char_code = c;
    in_ch.position  = p;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = console_apply(f, c, p);
    pending_results.push_back(typed ? typed_resp : r);
    requests_sent++;
  endtask

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                       input logic [POS_W-1:0] p);
    send_request(f, c, p, 1'b0, '0);
  endtask

  // stop offering and let every response come back
  task automatic drain_requests();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_color(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_FG) fg_model = val;
    else bg_model = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic text_burst();
    int sel;
    int len;
    int rp;
    logic [POS_W-1:0]  start;
    logic [CHAR_W-1:0] ch;
    sel = $urandom_range(0, 99);
    if (sel < 25) start = POS_W'($urandom_range(CELLS - COLS, CELLS - 1));
    else if (sel < 35) start = POS_W'($urandom_range(0, ROWS - 1) * COLS);
    else start = POS_W'($urandom_range(0, CELLS - 1));
    issue(FN_SETCUR, CHAR_W'($urandom_range(0, 255)), start);
    len = $urandom_range(3, 16);
    repeat (len) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) ch = CH_NEWLINE;
      else if (sel < 16) ch = CH_BACKSPACE;
      else ch = CHAR_W'($urandom_range(0, 255));
      issue(FN_PUT, ch, POS_W'($urandom_range(0, 2047)));
    end
    // read back around what was just written
    repeat ($urandom_range(1, 3)) begin
      rp = cursor_model - int'($urandom_range(0, 40));
      if (rp < 0) rp = 0;
      issue(FN_READ, CHAR_W'($urandom_range(0, 255)), POS_W'(rp));
    end
  endtask

  task automatic random_mix(input int target);
    int sel;
    logic [FUNC_W-1:0] f;
    while (requests_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        text_burst();
      end else if (sel < 75) begin
        repeat ($urandom_range(3, 8)) issue(FN_READ, CHAR_W'($urandom_range(0, 255)),
                                            POS_W'($urandom_range(0, 2047)));
      end else if (sel < 97) begin
        repeat ($urandom_range(1, 6)) begin
          f = FUNC_W'($urandom_range(0, 3));
          // clears walk the whole store, keep them rare
          if (f == FN_CLEAR && $urandom_range(0, 9) != 0) f = FN_READ;
          issue(f, CHAR_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 2047)));
        end
      end else begin
        issue(FN_CLEAR, CHAR_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 2047)));
        repeat ($urandom_range(1, 3))
          issue(FN_READ, 8'h00, POS_W'($urandom_range(0, CELLS - 1)));
      end
    end
  endtask

  // response side: random stalls, one long hold-off on request, checking
  initial begin : response_side
    console_resp_t want;
    int w;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        w = $urandom_range(0, stall_max);
        if (w > 0) begin
          out_ch.ready = 1'b0;
          repeat (w) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected response cursor=%0d cell=%h", out_ch.cursor_pos,
                   out_ch.cell_data);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.cursor_pos !== want.cursor || out_ch.cell_data !== want.cell_word) begin
          errors++;
          if (errors <= 10)
            $display("tb: mismatch cursor exp=%0d got=%0d cell exp=%h got=%h",
                     want.cursor, out_ch.cursor_pos, want.cell_word, out_ch.cell_data);
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] fg_set [0:PHASES-1];
    logic [CFG_DATA_W-1:0] bg_set [0:PHASES-1];
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_PUT;
    in_ch.char_code = '0;
    in_ch.position  = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_FG;
    cfg_wdata       = '0;
    errors          = 0;
    requests_sent   = 0;
    gap_max         = MAX_WAIT;
    stall_max       = MAX_WAIT;
    hold_req        = 1'b0;
    cursor_model    = 0;
    fg_model        = FG_RESET;
    bg_model        = BG_RESET;
    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;

    fg_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0};
    bg_set = '{4'h0, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0};
    for (int i = 4; i < PHASES; i++) begin
      fg_set[i] = CFG_DATA_W'($urandom_range(0, 15));
      bg_set[i] = CFG_DATA_W'($urandom_range(0, 15));
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].func, directed_rows[i].char_code,
                   directed_rows[i].position, directed_rows[i].typed,
                   '{directed_rows[i].cursor, directed_rows[i].cell_word});

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_requests();
      repeat (4) @(posedge clk);
      write_color(CFG_FG, fg_set[ph]);
      write_color(CFG_BG, bg_set[ph]);
      gap_max   = (ph % 3 == 1) ? 0 : MAX_WAIT;
      stall_max = (ph % 3 == 2 || ph == 4) ? 0 : MAX_WAIT;
      if (ph == 4) gap_max = 0;
      // long receiver hold-off while requests keep coming
      if (ph == 2) hold_req = 1'b1;
      random_mix(DIR_N + (ph + 1) * (RANDOM_ITEMS / PHASES));
    end

    drain_requests();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'(TIMEOUT_CYCLES) * 2 * CLK_HALF);
    $display("tb: failure");
    $finish;
  end

endmodule
